FILE: rtl/sdrs_pkg.sv
package sdrs_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int TAG_W   = 16;
    localparam int KEY_W   = 22;
    // Width of an unsaturated key: 16383 * 365 plus the small terms stays below 2**23.
    localparam int SUM_W   = 23;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } rec_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        rec_t             rec;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_RD,
        ST_CMP,
        ST_PUT,
        ST_DRD,
        ST_DLOAD,
        ST_DWAIT
    } state_t;

    // Days before the first of month m in a common year. Month zero adds nothing,
    // months above twelve add the whole year.
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd0, 4'd1: d = 9'd0;
            4'd2:       d = 9'd31;
            4'd3:       d = 9'd59;
            4'd4:       d = 9'd90;
            4'd5:       d = 9'd120;
            4'd6:       d = 9'd151;
            4'd7:       d = 9'd181;
            4'd8:       d = 9'd212;
            4'd9:       d = 9'd243;
            4'd10:      d = 9'd273;
            4'd11:      d = 9'd304;
            4'd12:      d = 9'd334;
            default:    d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/sdrs_ram.sv
module sdrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/sdrs_key.sv
module sdrs_key
    import sdrs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [DAY_W-1:0]   day,
    input  logic [MONTH_W-1:0] month,
    input  logic [YEAR_W-1:0]  year,
    output logic               out_valid,
    output logic [KEY_W-1:0]   key
);

    // Stage 1: the two multiplications. year / 100 is (year / 4) / 25, taken as
    // (year / 4) * 5243 >> 17, which is exact for every 12-bit quotient.
    logic [2:0]         valid_reg;
    logic [SUM_W-1:0]   p365_reg;
    logic [24:0]        p25_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [MONTH_W-1:0] month_reg;

    // Stage 2: quotient by 100, leap flag and the positive partial sum.
    logic [7:0]         q100_reg;
    logic               leap_add_reg;
    logic [SUM_W-1:0]   partial_reg;

    logic [KEY_W-1:0]   key_reg;

    logic [7:0]         q100;
    logic [14:0]        back100;
    logic               leap;
    logic [SUM_W-1:0]   partial;
    logic [SUM_W-1:0]   sum;

    assign q100    = p25_reg[24:17];
    assign back100 = q100 * 15'd100;
    assign leap    = (year_reg[1:0] == 2'b00) &&
                     ((back100 != {1'b0, year_reg}) || (q100[1:0] == 2'b00));
    assign partial = p365_reg + SUM_W'(year_reg[YEAR_W-1:2]) + SUM_W'(1)
                   + SUM_W'(month_start(month_reg)) + SUM_W'(day_reg);
    assign sum     = partial_reg - SUM_W'(q100_reg) + SUM_W'(q100_reg[7:2])
                   + SUM_W'(leap_add_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        p365_reg     <= SUM_W'(year) * SUM_W'(365);
        p25_reg      <= year[YEAR_W-1:2] * 13'd5243;
        year_reg     <= year;
        day_reg      <= day;
        month_reg    <= month;
        q100_reg     <= q100;
        leap_add_reg <= leap && (month_reg > 4'd2);
        partial_reg  <= partial;
        key_reg      <= (sum > SUM_W'(KEY_MAX)) ? KEY_MAX : sum[KEY_W-1:0];
    end

    assign out_valid = valid_reg[2];
    assign key       = key_reg;

endmodule

FILE: rtl/stable_date_record_sorter.sv
// Channel  Direction  Ports                                        Moves
// s_       in         s_valid/s_ready, s_start_*, s_record_tag,    one record word
//                     s_last_record
// m_       out        m_valid/m_ready, m_out_tag/day/month/year,   one sorted record word
//                     m_out_last
//
// A record is accepted, waits for its key, then takes a read and a compare for each stored
// record it moves past plus the first one it stops at, and is written in place last.
// A record that finds the set full is dropped right after the key wait.
// Draining reads, loads and then offers each result word, and waits while m_ready is low.
// Reset (aresetn low, synchronous) empties the set; memory contents need no clearing.
// s_ready is high only while the block waits for a record.
module stable_date_record_sorter
    import sdrs_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DAY_W-1:0]   s_start_day,
    input  logic [MONTH_W-1:0] s_start_month,
    input  logic [YEAR_W-1:0]  s_start_year,
    input  logic [TAG_W-1:0]   s_record_tag,
    input  logic               s_last_record,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [TAG_W-1:0]   m_out_tag,
    output logic [DAY_W-1:0]   m_out_day,
    output logic [MONTH_W-1:0] m_out_month,
    output logic [YEAR_W-1:0]  m_out_year,
    output logic               m_out_last
);

    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int ENT_W = $bits(entry_t);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [KEY_W-1:0] key_reg;
    rec_t             rec_reg;
    logic             last_reg;
    rec_t             out_rec_reg;
    logic             out_last_reg;

    logic             accept;
    logic             key_valid;
    logic [KEY_W-1:0] key_value;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;
    entry_t           rd_entry;
    logic             store_full;
    logic             move_up;
    logic             drain_end;

    assign accept     = s_valid && s_ready;
    assign rd_entry   = entry_t'(ram_rdata);
    assign store_full = (count_reg == CNT_W'(MAX_RECORDS));
    // Stability: an earlier record moves up only when its key is strictly greater.
    assign move_up    = (rd_entry.key > key_reg);
    assign drain_end  = (CNT_W'(idx_reg) + CNT_W'(1) == count_reg);

    sdrs_key u_key (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .day       (s_start_day),
        .month     (s_start_month),
        .year      (s_start_year),
        .out_valid (key_valid),
        .key       (key_value)
    );

    sdrs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_KEY;
                end
            end
            ST_KEY: begin
                if (key_valid) begin
                    if (store_full) begin
                        state_next = last_reg ? ST_DRD : ST_IDLE;
                    end else if (count_reg == '0) begin
                        state_next = ST_PUT;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (move_up && (j_reg != IDX_W'(1))) begin
                    state_next = ST_RD;
                end else begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                state_next = last_reg ? ST_DRD : ST_IDLE;
            end
            ST_DRD: begin
                state_next = ST_DLOAD;
            end
            ST_DLOAD: begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (m_ready) begin
                    state_next = drain_end ? ST_IDLE : ST_DRD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and memory controls.
    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = j_reg;
        ram_wdata = ram_rdata;
        ram_raddr = j_reg - IDX_W'(1);
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_CMP: begin
                ram_we = move_up;
            end
            ST_PUT: begin
                ram_we    = 1'b1;
                ram_wdata = {key_reg, rec_reg};
            end
            ST_DRD: begin
                ram_raddr = idx_reg;
            end
            ST_DWAIT: begin
                m_valid = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            j_reg     <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_KEY && key_valid) begin
                j_reg   <= count_reg[IDX_W-1:0];
                idx_reg <= '0;
            end
            if (state_reg == ST_CMP && move_up) begin
                j_reg <= j_reg - IDX_W'(1);
            end
            if (state_reg == ST_PUT) begin
                count_reg <= count_reg + CNT_W'(1);
                idx_reg   <= '0;
            end
            if (state_reg == ST_DWAIT && m_ready) begin
                if (drain_end) begin
                    count_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rec_reg.tag   <= s_record_tag;
            rec_reg.day   <= s_start_day;
            rec_reg.month <= s_start_month;
            rec_reg.year  <= s_start_year;
            last_reg      <= s_last_record;
        end
        if (state_reg == ST_KEY && key_valid) begin
            key_reg <= key_value;
        end
        if (state_reg == ST_DLOAD) begin
            out_rec_reg  <= rd_entry.rec;
            out_last_reg <= drain_end;
        end
    end

    assign m_out_tag   = out_rec_reg.tag;
    assign m_out_day   = out_rec_reg.day;
    assign m_out_month = out_rec_reg.month;
    assign m_out_year  = out_rec_reg.year;
    assign m_out_last  = out_last_reg;

`ifndef SYNTH
    // The set never grows past the memory depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count exceeds depth");

    // The key pipeline only delivers while the controller waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        key_valid |-> (state_reg == ST_KEY))
        else $error("key result outside key wait");

    // Once the final word of a run is taken, the set is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_out_last) |=> (count_reg == '0) && s_ready)
        else $error("set not emptied after final word");
`endif

endmodule

FILE: verif/stable_date_record_sorter_tb.sv
module stable_date_record_sorter_tb
    import sdrs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RECORDS = 64;
    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    // The slowest correct run stays far below this count, even when records
    // sort into a full set, result words wait on receiver stalls and the
    // receiver holds off once for a long stretch.
    localparam int CYCLE_LIMIT = 1000000;
    // Once the last expected word has come, this many cycles are watched for
    // stray output before the verdict.
    localparam int TAIL_CYCLES = 60;
    localparam int RANDOM_WORDS_PER_PHASE = 50;

    // One expected output word: the record in its sorted place, and the flag
    // that marks the end of the run.
    typedef struct packed {
        rec_t rec;
        logic last;
    } sorted_word_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [DAY_W-1:0]   s_start_day   = '0;
    logic [MONTH_W-1:0] s_start_month = '0;
    logic [YEAR_W-1:0]  s_start_year  = '0;
    logic [TAG_W-1:0]   s_record_tag  = '0;
    logic               s_last_record = 1'b0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [TAG_W-1:0]   m_out_tag;
    logic [DAY_W-1:0]   m_out_day;
    logic [MONTH_W-1:0] m_out_month;
    logic [YEAR_W-1:0]  m_out_year;
    logic               m_out_last;

    // The records of the set that is being collected, kept in stable key order,
    // and the output words that the sorted sets still owe.
    entry_t       open_set[$];
    sorted_word_t words_due[$];

    int unsigned idle_pct   = 0;
    int unsigned stall_pct  = 0;
    int unsigned hold_left  = 0;
    int unsigned words_sent = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    stable_date_record_sorter #(
        .MAX_RECORDS(MAX_RECORDS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_day  (s_start_day),
        .s_start_month(s_start_month),
        .s_start_year (s_start_year),
        .s_record_tag (s_record_tag),
        .s_last_record(s_last_record),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_tag    (m_out_tag),
        .m_out_day    (m_out_day),
        .m_out_month  (m_out_month),
        .m_out_year   (m_out_year),
        .m_out_last   (m_out_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Length of a month in a common year. The leap day is added on its own.
    function automatic int unsigned month_length(input int unsigned mo);
        case (mo)
            2:              return 28;
            4, 6, 9, 11:    return 30;
            default:        return 31;
        endcase
    endfunction

    // Day number of a date. Year 0 counts as a leap year, so the leap-year term
    // starts at one. Month zero adds no month days, and months above twelve add
    // the whole year. Days are taken as given, even zero or past the month's end.
    // Keys that do not fit 22 bits saturate, which happens only for years past
    // about 11480.
    function automatic logic [KEY_W-1:0] day_number(input rec_t r);
        int unsigned yr;
        int unsigned k;
        logic        leap;
        yr   = 32'(r.year);
        leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
        k    = yr * 365 + yr / 4 - yr / 100 + yr / 400 + 1 + 32'(r.day);
        for (int unsigned mo = 1; mo < 32'(r.month) && mo <= 12; mo++) begin
            k += month_length(mo);
        end
        if (32'(r.month) > 2 && leap) begin
            k++;
        end
        if (k > 32'(KEY_MAX)) begin
            k = 32'(KEY_MAX);
        end
        return k[KEY_W-1:0];
    endfunction

    // Files one accepted record into the open set. A record is placed ahead of
    // the first one with a strictly greater key, so equal keys keep their
    // arrival order. A full set drops the record, but its last flag still
    // closes the set, and the whole set then becomes expected output.
    function automatic void sort_into_set(input rec_t r, input logic last);
        entry_t       e;
        sorted_word_t w;
        int           pos;
        if (open_set.size() < MAX_RECORDS) begin
            e.rec = r;
            e.key = day_number(r);
            pos   = open_set.size();
            for (int i = 0; i < open_set.size(); i++) begin
                if (open_set[i].key > e.key) begin
                    pos = i;
                    break;
                end
            end
            open_set.insert(pos, e);
        end
        if (last) begin
            foreach (open_set[i]) begin
                w.rec  = open_set[i].rec;
                w.last = (i == open_set.size() - 1);
                words_due.push_back(w);
            end
            open_set.delete();
        end
    endfunction

    function automatic rec_t dated(input logic [TAG_W-1:0] tag, input int unsigned d,
                                   input int unsigned mo, input int unsigned yr);
        rec_t r;
        r.tag   = tag;
        r.day   = DAY_W'(d);
        r.month = MONTH_W'(mo);
        r.year  = YEAR_W'(yr);
        return r;
    endfunction

    // A random date. Most are plausible calendar dates; the rest reach
    // across every value that the fields can carry.
    function automatic rec_t random_record();
        rec_t        r;
        int unsigned pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3, 4: r.year = YEAR_W'($urandom_range(9999));
            5, 6:          r.year = YEAR_W'($urandom_range(16383));
            7:             r.year = YEAR_W'($urandom_range(99) * 100);
            8:             r.year = YEAR_W'($urandom_range(2499) * 4);
            default:       r.year = $urandom_range(1) ? YEAR_W'(16383) : '0;
        endcase
        r.month = MONTH_W'(($urandom_range(99) < 85) ? $urandom_range(12, 1)
                                                     : $urandom_range(15));
        r.day   = DAY_W'(($urandom_range(99) < 80) ? $urandom_range(28, 1)
                                                   : $urandom_range(31));
        r.tag   = TAG_W'($urandom);
        return r;
    endfunction

    // Offers one record word and waits for its handshake. Random idle cycles
    // are put in front of the word as idle_pct asks. The valid is not lowered
    // after the handshake here: the next call or stop-and-wait does that, so
    // that back-to-back words keep valid high without a glitch.
    task automatic send_record(input rec_t r, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_start_day   <= r.day;
        s_start_month <= r.month;
        s_start_year  <= r.year;
        s_record_tag  <= r.tag;
        s_last_record <= last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sort_into_set(r, last);
        words_sent++;
    endtask

    // Stops offering words and waits until every expected result has come.
    // It waits on the clock before the first check, so a following send never drives valid twice
    // in the same time step.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (words_due.size() != 0);
    endtask

    // Sends one set of random records with the last word marked. Some sets
    // draw their dates from a small pool so that equal keys are common and
    // the stability of the sort is put to work.
    task automatic send_random_set(input int unsigned count);
        rec_t pool[3];
        rec_t r;
        logic pooled;
        pooled = ($urandom_range(99) < 30);
        foreach (pool[i]) begin
            pool[i] = random_record();
        end
        for (int unsigned i = 0; i < count; i++) begin
            r = random_record();
            if (pooled) begin
                r     = pool[$urandom_range(2)];
                r.tag = TAG_W'($urandom);
            end
            send_record(r, i == count - 1);
        end
    endtask

    // Directed dates: field extremes, leap-year rules, month zero and months
    // above twelve, saturated keys, and equal keys that must keep their order.
    task automatic test_directed_dates();
        // A set of one record, at the top of the tag, day and year fields; its key saturates.
        send_record(dated(16'hFFFF, 31, 12, 16383), 1'b1);

        send_record(dated(16'h0000, 0, 0, 0), 1'b0);
        send_record(dated(16'h0001, 31, 15, 0), 1'b0);
        send_record(dated(16'h0002, 29, 2, 2000), 1'b0);
        send_record(dated(16'h0003, 1, 3, 2000), 1'b0);
        send_record(dated(16'h0004, 1, 3, 1900), 1'b0);
        send_record(dated(16'h0005, 1, 3, 2004), 1'b0);
        send_record(dated(16'h0006, 31, 12, 9999), 1'b0);
        send_record(dated(16'h0007, 1, 1, 10000), 1'b0);
        // Both keys saturate, so they tie and must come out in this order.
        send_record(dated(16'h0008, 5, 6, 12000), 1'b0);
        send_record(dated(16'h0009, 1, 1, 16383), 1'b0);
        // January 31 and February 0 give the same day number.
        send_record(dated(16'h000A, 31, 1, 2023), 1'b0);
        send_record(dated(16'h000B, 0, 2, 2023), 1'b0);
        send_record(dated(16'h000C, 15, 6, 1984), 1'b0);
        send_record(dated(16'h000D, 15, 6, 1984), 1'b0);
        send_record(dated(16'hAAAA, 21, 10, 10922), 1'b0);
        send_record(dated(16'h5555, 10, 5, 5461), 1'b1);

        // Two records that arrive in falling order must swap.
        send_record(dated(16'h1234, 2, 1, 2024), 1'b0);
        send_record(dated(16'h4321, 1, 1, 2024), 1'b1);
        wait_for_results();
    endtask

    // More records than the store holds: the extra ones, the last among them,
    // are dropped, and the last flag still releases the full set.
    task automatic test_store_overflow();
        send_random_set(MAX_RECORDS + 2);
        wait_for_results();
    endtask

    // Random sets, mostly small, a few near or past the store's size.
    task automatic test_random_sets(input int unsigned idle, input int unsigned stall);
        int unsigned start;
        int unsigned pick;
        idle_pct  = idle;
        stall_pct = stall;
        start     = words_sent;
        while (words_sent - start < RANDOM_WORDS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_random_set($urandom_range(8, 1));
            end else if (pick < 96) begin
                send_random_set($urandom_range(24, 9));
            end else begin
                send_random_set($urandom_range(MAX_RECORDS + 2, 40));
            end
        end
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering the next set. The block must hold the sorted words and stall
    // its input until the receiver lets them out.
    task automatic test_output_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 2000;
        send_random_set(12);
        send_random_set(8);
        wait_for_results();
    endtask

    // The receiver's ready: held low while a hold-off counts down, otherwise
    // low at random in stall_pct of the cycles.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    // Every output word that passes its handshake is checked against the
    // oldest expected word.
    always @(posedge aclk) begin : result_check
        sorted_word_t due;
        if (aresetn && m_valid && m_ready) begin
            if (words_due.size() == 0) begin
                $error("unexpected output word: tag %0d day %0d month %0d year %0d",
                       m_out_tag, m_out_day, m_out_month, m_out_year);
                error_count++;
            end else begin
                due = words_due.pop_front();
                check_field("out_tag", 32'(due.rec.tag), 32'(m_out_tag));
                check_field("out_day", 32'(due.rec.day), 32'(m_out_day));
                check_field("out_month", 32'(due.rec.month), 32'(m_out_month));
                check_field("out_year", 32'(due.rec.year), 32'(m_out_year));
                check_field("out_last", 32'(due.last), 32'(m_out_last));
            end
        end
    end

    // A hung block ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_dates();
        test_store_overflow();
        test_random_sets(0, 0);
        test_random_sets(49, 0);
        test_random_sets(0, 49);
        test_random_sets(33, 33);
        test_output_backpressure();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && words_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
